// ----- hw/rtl/csmv_pkg.sv -----
// Shared types and constants for the CSR sparse matrix-vector block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package csmv_pkg;

  localparam int MAX_DIM_DEF = 1024;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 10;
  localparam int VAL_W       = 32;
  localparam int ACC_W       = 64;

  // Request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_EMPTY   = 2'd2
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
    logic                    last;
    logic [ROW_W-1:0]        row;
  } q_item_t;

endpackage

// ----- hw/rtl/csr_sparse_matvec_top.sv -----
// Top level of the complex CSR sparse matrix-vector block.
// Instantiates csmv_front, csmv_queue and csmv_back; depends on csmv_pkg.
//
// Requests stream in at one per cycle while in_stall is low: a load writes one
// complex element of x into the on-chip vector store (MAX_DIM entries of 64
// bits, imaginary part high), a nonzero multiplies its Q2.29 complex value by
// x at its column and adds the exact Q5.58 product into two 64-bit saturating
// sums, and the last nonzero of a row, or an empty-row request, returns one
// result: the row number, both sums rounded half-up to Q2.29 and clamped, and
// a flag set if anything saturated in that row. Loads restart the row count at
// zero. The sustained rate is one request per cycle while out_stall is low;
// the limit is the single port of the vector store, which each request uses
// at most once. The front tags requests with their row and drops the unused
// operation code; a four-deep queue holds them so the front keeps taking
// requests while the back waits on out_stall. The back is a five-stage
// pipeline (store read, partial products, complex sum, accumulate, round)
// ending in the output register. The vector store is not cleared at reset:
// read only entries already loaded.
`timescale 1ns / 1ps

module csr_sparse_matvec_top #(
  parameter int MAX_DIM = csmv_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_operation,
  input  logic [csmv_pkg::COL_W-1:0]        in_column,
  input  logic signed [csmv_pkg::VAL_W-1:0] in_value_re,
  input  logic signed [csmv_pkg::VAL_W-1:0] in_value_im,
  input  logic                              in_last_in_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [csmv_pkg::ROW_W-1:0]        out_row_index,
  output logic signed [csmv_pkg::VAL_W-1:0] out_sum_re,
  output logic signed [csmv_pkg::VAL_W-1:0] out_sum_im,
  output logic                              out_saturated
);
  import csmv_pkg::*;

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  q_item_t q_in;
  q_item_t q_head;

  // Accept, classify and tag with the row number
  csmv_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_column      (in_column),
    .in_value_re    (in_value_re),
    .in_value_im    (in_value_im),
    .in_last_in_row (in_last_in_row),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  // Hold requests so each side can stall on its own
  csmv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Store access, multiply, accumulate, round and drive the result channel
  csmv_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_sum_re    (out_sum_re),
    .out_sum_im    (out_sum_im),
    .out_saturated (out_saturated)
  );

endmodule

// ----- hw/rtl/csmv_front.sv -----
// Front end: accepts input requests, drops unused codes and tags each request
// with its row number. Depends on csmv_pkg.
`timescale 1ns / 1ps

module csmv_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_operation,
  input  logic [csmv_pkg::COL_W-1:0]    in_column,
  input  logic signed [csmv_pkg::VAL_W-1:0] in_value_re,
  input  logic signed [csmv_pkg::VAL_W-1:0] in_value_im,
  input  logic                          in_last_in_row,
  input  logic                          q_full,
  output logic                          q_push,
  output csmv_pkg::q_item_t             q_item
);
  import csmv_pkg::*;

  logic [ROW_W-1:0] row_cnt_r;
  logic [ROW_W-1:0] row_cnt_nxt;
  logic             accept;
  logic             useful;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    useful      = 1'b0;
    row_cnt_nxt = row_cnt_r;
    case (in_operation)
      OP_LOAD: begin
        useful      = 1'b1;
        row_cnt_nxt = '0;
      end
      OP_NONZERO: begin
        useful = 1'b1;
        if (in_last_in_row) begin
          row_cnt_nxt = row_cnt_r + ROW_W'(1);
        end
      end
      OP_EMPTY: begin
        useful      = 1'b1;
        row_cnt_nxt = row_cnt_r + ROW_W'(1);
      end
      default: begin
        useful      = 1'b0;
        row_cnt_nxt = row_cnt_r;
      end
    endcase
  end

  assign q_push = accept && useful;

  always_comb begin
    q_item.op     = op_t'(in_operation);
    q_item.column = in_column;
    q_item.re     = in_value_re;
    q_item.im     = in_value_im;
    q_item.last   = in_last_in_row;
    q_item.row    = row_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
    end else if (accept) begin
      row_cnt_r <= row_cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/csmv_queue.sv -----
// Short request queue between front and back end.
// Depends on csmv_pkg for the request type and depth.
`timescale 1ns / 1ps

module csmv_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  csmv_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output csmv_pkg::q_item_t head
);
  import csmv_pkg::*;

  q_item_t        slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] count_r;
  logic           do_push;
  logic           do_pop;

  assign full    = (count_r == QCW'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCW'(1);
        2'b01:   count_r <= count_r - QCW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- hw/rtl/csmv_back.sv -----
// Back end: vector store, complex multiply, saturating accumulate, rounding
// and the output register. Depends on csmv_pkg.
`timescale 1ns / 1ps

module csmv_back #(
  parameter int MAX_DIM = csmv_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  csmv_pkg::q_item_t                 q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [csmv_pkg::ROW_W-1:0]        out_row_index,
  output logic signed [csmv_pkg::VAL_W-1:0] out_sum_re,
  output logic signed [csmv_pkg::VAL_W-1:0] out_sum_im,
  output logic                              out_saturated
);
  import csmv_pkg::*;

  localparam int AW = $clog2(MAX_DIM);
  localparam int XW = (AW > COL_W) ? AW : COL_W;

  typedef struct packed {
    logic signed [ACC_W-1:0] val;
    logic                    ovf;
  } sat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic                    clamp;
  } rnd_t;

  function automatic sat_t sat_add(logic signed [ACC_W-1:0] a,
                                   logic signed [ACC_W-1:0] b);
    sat_t                    r;
    logic signed [ACC_W-1:0] s;
    s     = a + b;
    r.ovf = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
    if (r.ovf) begin
      r.val = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r.val = s;
    end
    return r;
  endfunction

  // Q5.58 to Q2.29: floor(a / 2^29 + 1/2), clamped to 32 bits
  function automatic rnd_t round_q29(logic signed [ACC_W-1:0] a);
    rnd_t        r;
    logic [35:0] t;
    t       = {a[63], a[63:29]} + {35'd0, a[28]};
    r.clamp = (t[35:31] != {5{t[31]}});
    if (r.clamp) begin
      r.val = t[35] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      r.val = t[31:0];
    end
    return r;
  endfunction

  logic                    adv;
  logic                    in_range;
  logic [XW-1:0]           col_ext;
  logic [AW-1:0]           addr;

  logic [2*VAL_W-1:0]      mem [MAX_DIM];
  logic [2*VAL_W-1:0]      rd_data_r;

  // stage 1: store access
  logic                    s1_v_r;
  q_item_t                 s1_item_r;
  logic                    s1_inr_r;
  logic signed [VAL_W-1:0] x_re;
  logic signed [VAL_W-1:0] x_im;

  // stage 2: partial products
  logic                    s2_v_r;
  op_t                     s2_op_r;
  logic                    s2_last_r;
  logic [ROW_W-1:0]        s2_row_r;
  logic signed [ACC_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;

  // stage 3: complex product
  logic                    s3_v_r;
  op_t                     s3_op_r;
  logic                    s3_last_r;
  logic [ROW_W-1:0]        s3_row_r;
  logic signed [ACC_W-1:0] prod_re_r, prod_im_r;

  // stage 4: accumulators and row total
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic                    sat_seen_r;
  sat_t                    add_re, add_im;
  logic                    tot_v_r;
  logic [ROW_W-1:0]        tot_row_r;
  logic signed [ACC_W-1:0] tot_re_r, tot_im_r;
  logic                    tot_sat_r;

  // stage 5: output register
  rnd_t                    rnd_re, rnd_im;
  logic                    out_valid_r;
  logic [ROW_W-1:0]        out_row_r;
  logic signed [VAL_W-1:0] out_re_r, out_im_r;
  logic                    out_sat_r;

  assign adv      = !out_valid_r || !out_stall;
  assign q_pop    = adv && !q_empty;
  assign in_range = (32'(q_head.column) < 32'(MAX_DIM));
  assign col_ext  = XW'(q_head.column);
  assign addr     = col_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (q_pop && in_range) begin
      if (q_head.op == OP_LOAD) begin
        mem[addr] <= {q_head.im, q_head.re};
      end else begin
        rd_data_r <= mem[addr];
      end
    end
  end

  assign x_re = s1_inr_r ? rd_data_r[VAL_W-1:0]       : '0;
  assign x_im = s1_inr_r ? rd_data_r[2*VAL_W-1:VAL_W] : '0;

  assign add_re = sat_add(acc_re_r, prod_re_r);
  assign add_im = sat_add(acc_im_r, prod_im_r);
  assign rnd_re = round_q29(tot_re_r);
  assign rnd_im = round_q29(tot_im_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      tot_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      acc_re_r    <= '0;
      acc_im_r    <= '0;
      sat_seen_r  <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= q_pop;
      s2_v_r      <= s1_v_r && (s1_item_r.op != OP_LOAD);
      s3_v_r      <= s2_v_r;
      tot_v_r     <= s3_v_r && ((s3_op_r == OP_EMPTY) || s3_last_r);
      out_valid_r <= tot_v_r;
      if (s3_v_r) begin
        if ((s3_op_r == OP_EMPTY) || s3_last_r) begin
          acc_re_r   <= '0;
          acc_im_r   <= '0;
          sat_seen_r <= 1'b0;
        end else begin
          acc_re_r   <= add_re.val;
          acc_im_r   <= add_im.val;
          sat_seen_r <= sat_seen_r | add_re.ovf | add_im.ovf;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= q_head;
      s1_inr_r  <= in_range;

      s2_op_r   <= s1_item_r.op;
      s2_last_r <= s1_item_r.last;
      s2_row_r  <= s1_item_r.row;
      p_rr_r    <= s1_item_r.re * x_re;
      p_ii_r    <= s1_item_r.im * x_im;
      p_ri_r    <= s1_item_r.re * x_im;
      p_ir_r    <= s1_item_r.im * x_re;

      s3_op_r   <= s2_op_r;
      s3_last_r <= s2_last_r;
      s3_row_r  <= s2_row_r;
      prod_re_r <= p_rr_r - p_ii_r;
      prod_im_r <= p_ri_r + p_ir_r;

      tot_row_r <= s3_row_r;
      if (s3_op_r == OP_EMPTY) begin
        tot_re_r  <= '0;
        tot_im_r  <= '0;
        tot_sat_r <= 1'b0;
      end else begin
        tot_re_r  <= add_re.val;
        tot_im_r  <= add_im.val;
        tot_sat_r <= sat_seen_r | add_re.ovf | add_im.ovf;
      end

      out_row_r <= tot_row_r;
      out_re_r  <= rnd_re.val;
      out_im_r  <= rnd_im.val;
      out_sat_r <= tot_sat_r | rnd_re.clamp | rnd_im.clamp;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_sum_re    = out_re_r;
  assign out_sum_im    = out_im_r;
  assign out_saturated = out_sat_r;

endmodule
